// ===== rtl/pid_with_deadband_macros.svh =====
// ----------------------------------------------------------------------------
// pid_with_deadband assertion macros
// shared immediate-implication and next-cycle checks on clk, disabled in rst
// ----------------------------------------------------------------------------
`ifndef PID_WITH_DEADBAND_MACROS_SVH
`define PID_WITH_DEADBAND_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define PWD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PWD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pwd_pkg.sv =====
// ----------------------------------------------------------------------------
// pwd_pkg
// shared widths, constants, register indexes and state codes of the pid block
// ----------------------------------------------------------------------------
package pwd_pkg;

  localparam int DEF_DATA_WIDTH  = 32;
  localparam int DEF_FRAC_BITS   = 16;
  localparam int DEF_MIN_STEP_US = 100;

  localparam int STEP_W    = 20;
  localparam int US_W      = 20;
  localparam int GAIN_W    = 32;
  localparam int CLAMP_W   = 31;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int ACC_W     = 48;
  localparam int TERM_W    = 64;

  localparam logic [US_W-1:0]   US_PER_S = 20'd1000000;
  localparam logic [TERM_W-1:0] TERM_LIM = 64'h4000_0000_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_DEAD_ZONE   = 3'd3,
    REG_INTEG_CLAMP = 3'd4,
    REG_DRIVE_CLAMP = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PREP,
    ST_MULA,
    ST_DIV,
    ST_INTEG,
    ST_GAIN,
    ST_MULB,
    ST_TERM,
    ST_ADD1,
    ST_ADD2,
    ST_LIMIT,
    ST_OUT
  } state_t;

  function automatic logic [GAIN_W-1:0] mag_gain(input logic [GAIN_W-1:0] g);
    mag_gain = g[GAIN_W-1] ? (~g + 1'b1) : g;
  endfunction

endpackage

// ===== rtl/pid_with_deadband.sv =====
// ----------------------------------------------------------------------------
// pid_with_deadband
// fixed-point pid controller with deadband, integral clamp and output limit
// ----------------------------------------------------------------------------
// One result per transfer. An error inside the deadband goes from accept
// through ST_CHECK straight to ST_OUT and back to ready. Any other error
// makes two passes through three bit-serial 32-step multipliers (error*step
// and delta*1e6, then the three gain products) and one pass through two
// bit-serial dividers of DIV_W steps, the larger of DATA_WIDTH+20 and ACC_W
// ((error*step)/1e6 and (delta*1e6)/step). A finished result sits in the
// output register, so the next item is accepted while it waits. The user
// must see that configuration is written through cfg_we, cfg_addr and
// cfg_wdata only while no item is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "pid_with_deadband_macros.svh"

module pid_with_deadband import pwd_pkg::*; #(
  parameter int DATA_WIDTH  = DEF_DATA_WIDTH,
  parameter int FRAC_BITS   = DEF_FRAC_BITS,
  parameter int MIN_STEP_US = DEF_MIN_STEP_US
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DATA_WIDTH-1:0] err_in,
  input  logic [STEP_W-1:0]     step_us,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH-1:0] drive,
  output logic                  in_dead_zone,
  output logic                  drive_limited
);

  localparam int DW     = DATA_WIDTH;
  localparam int MAG_W  = (DW > ACC_W) ? DW : ACC_W;
  localparam int P_W    = MAG_W + GAIN_W;
  localparam int DIV_W  = (DW + STEP_W > ACC_W) ? DW + STEP_W : ACC_W;
  localparam int SI_W   = DIV_W + 2;
  localparam int SY_W   = TERM_W + 2;
  localparam int N_LANE = 3;
  localparam int LANE_P = 0;
  localparam int LANE_I = 1;
  localparam int LANE_D = 2;
  localparam int DIV_I  = 0;
  localparam int DIV_D  = 1;

  localparam logic signed [SI_W-1:0] A_MAX = SI_W'((longint'(1) << (ACC_W - 1)) - 1);
  localparam logic signed [SI_W-1:0] A_MIN = SI_W'(-(longint'(1) << (ACC_W - 1)));
  localparam logic signed [SY_W-1:0] Y_MAX = SY_W'((longint'(1) << (DW - 1)) - 1);
  localparam logic signed [SY_W-1:0] Y_MIN = SY_W'(-(longint'(1) << (DW - 1)));
  localparam logic [DIV_W-1:0] D_CAP_P = DIV_W'((longint'(1) << (ACC_W - 1)) - 1);
  localparam logic [DIV_W-1:0] D_CAP_N = DIV_W'(longint'(1) << (ACC_W - 1));
  localparam logic [P_W-1:0]   T_LIM   = P_W'(TERM_LIM);

  state_t state, state_next;

  logic signed [GAIN_W-1:0] prop_gain, integ_gain, deriv_gain;
  logic [CLAMP_W-1:0]       dead_zone, integ_clamp, drive_clamp;

  logic signed [ACC_W-1:0]  integ_acc;
  logic signed [DW-1:0]     prev_err;

  logic signed [DW-1:0]     e_reg;
  logic [DW-1:0]            e_mag;
  logic [STEP_W-1:0]        step_eff;
  logic signed [DW:0]       diff_reg;
  logic signed [SI_W-1:0]   inc_reg;
  logic [MAG_W-1:0]         d_mag;
  logic signed [TERM_W-1:0] term [N_LANE];
  logic signed [SY_W-1:0]   y_acc;
  logic [DW-1:0]            res_drive;
  logic                     res_dz;
  logic                     res_lim;

  logic                     mul_start;
  logic                     div_start;
  logic                     out_load;
  logic [MAG_W-1:0]         mul_a [N_LANE];
  logic [GAIN_W-1:0]        mul_b [N_LANE];
  logic [P_W-1:0]           mul_prod [N_LANE];
  logic [N_LANE-1:0]        mul_done;
  logic [DIV_W-1:0]         div_quot [2];
  logic [1:0]               div_done;

  logic [DW-1:0]            e_mag_in;
  logic [STEP_W-1:0]        step_in;
  logic                     dead;
  logic [DW:0]              diff_abs;
  logic [ACC_W-1:0]         integ_mag;
  logic [N_LANE-1:0]        term_neg;
  logic [P_W-1:0]           sh;
  logic [P_W-1:0]           t_mag;
  logic signed [TERM_W-1:0] t_s;
  logic signed [TERM_W-1:0] term_v [N_LANE];
  logic signed [SI_W-1:0]   q_int_s;
  logic signed [SI_W-1:0]   inc_v;
  logic [DIV_W-1:0]         d_lim;
  logic [DIV_W-1:0]         d_sel;
  logic signed [SI_W-1:0]   i_sum;
  logic signed [SI_W-1:0]   ic_p;
  logic signed [SI_W-1:0]   i_new;
  logic signed [SY_W-1:0]   dc_p;
  logic signed [SY_W-1:0]   y_cl;
  logic signed [SY_W-1:0]   y_fin;
  logic                     lim_v;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain   <= '0;
      integ_gain  <= '0;
      deriv_gain  <= '0;
      dead_zone   <= '0;
      integ_clamp <= '0;
      drive_clamp <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_PROP_GAIN:   prop_gain   <= cfg_wdata[GAIN_W-1:0];
        REG_INTEG_GAIN:  integ_gain  <= cfg_wdata[GAIN_W-1:0];
        REG_DERIV_GAIN:  deriv_gain  <= cfg_wdata[GAIN_W-1:0];
        REG_DEAD_ZONE:   dead_zone   <= cfg_wdata[CLAMP_W-1:0];
        REG_INTEG_CLAMP: integ_clamp <= cfg_wdata[CLAMP_W-1:0];
        REG_DRIVE_CLAMP: drive_clamp <= cfg_wdata[CLAMP_W-1:0];
        default: ;
      endcase
    end
  end

  // operand selection: first pass forms the two numerators, second the gains
  always_comb begin
    diff_abs  = diff_reg[DW] ? -diff_reg : diff_reg;
    integ_mag = integ_acc[ACC_W-1] ? -integ_acc : integ_acc;
    mul_a[LANE_P] = MAG_W'(e_mag);
    mul_a[LANE_I] = (state == ST_GAIN) ? MAG_W'(integ_mag) : MAG_W'(diff_abs[DW-1:0]);
    mul_a[LANE_D] = d_mag;
    mul_b[LANE_P] = (state == ST_GAIN) ? mag_gain(prop_gain) : GAIN_W'(step_eff);
    mul_b[LANE_I] = (state == ST_GAIN) ? mag_gain(integ_gain) : GAIN_W'(US_PER_S);
    mul_b[LANE_D] = mag_gain(deriv_gain);
  end

  for (genvar i = 0; i < N_LANE; i++) begin : g_mul
    pwd_smul #(
      .A_W (MAG_W),
      .B_W (GAIN_W)
    ) u_mul (
      .clk   (clk),
      .rst   (rst),
      .start (mul_start),
      .a     (mul_a[i]),
      .b     (mul_b[i]),
      .done  (mul_done[i]),
      .prod  (mul_prod[i])
    );
  end

  pwd_sdiv #(
    .N_W (DIV_W),
    .D_W (STEP_W)
  ) u_div_int (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_prod[LANE_P][DIV_W-1:0]),
    .divisor  (STEP_W'(US_PER_S)),
    .done     (div_done[DIV_I]),
    .quot     (div_quot[DIV_I])
  );

  pwd_sdiv #(
    .N_W (DIV_W),
    .D_W (STEP_W)
  ) u_div_der (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_prod[LANE_I][DIV_W-1:0]),
    .divisor  (step_eff),
    .done     (div_done[DIV_D]),
    .quot     (div_quot[DIV_D])
  );

  // datapath arithmetic
  always_comb begin
    e_mag_in = err_in[DW-1] ? (~err_in + 1'b1) : err_in;
    step_in  = (step_us == '0) ? STEP_W'(MIN_STEP_US) : step_us;
    dead     = MAG_W'(e_mag) < MAG_W'(dead_zone);

    q_int_s = $signed(SI_W'(div_quot[DIV_I]));
    inc_v   = e_reg[DW-1] ? -q_int_s : q_int_s;
    d_lim   = diff_reg[DW] ? D_CAP_N : D_CAP_P;
    d_sel   = (div_quot[DIV_D] > d_lim) ? d_lim : div_quot[DIV_D];

    i_sum = SI_W'(integ_acc) + inc_reg;
    ic_p  = $signed(SI_W'(integ_clamp));
    if (integ_clamp != '0) begin
      if (i_sum > ic_p) begin
        i_new = ic_p;
      end else if (i_sum < -ic_p) begin
        i_new = -ic_p;
      end else begin
        i_new = i_sum;
      end
    end else begin
      if (i_sum > A_MAX) begin
        i_new = A_MAX;
      end else if (i_sum < A_MIN) begin
        i_new = A_MIN;
      end else begin
        i_new = i_sum;
      end
    end

    term_neg[LANE_P] = prop_gain[GAIN_W-1] ^ e_reg[DW-1];
    term_neg[LANE_I] = integ_gain[GAIN_W-1] ^ integ_acc[ACC_W-1];
    term_neg[LANE_D] = deriv_gain[GAIN_W-1] ^ diff_reg[DW];
    sh    = '0;
    t_mag = '0;
    t_s   = '0;
    for (int i = 0; i < N_LANE; i++) begin
      sh        = mul_prod[i] >> FRAC_BITS;
      t_mag     = (sh > T_LIM) ? T_LIM : sh;
      t_s       = $signed(TERM_W'(t_mag));
      term_v[i] = term_neg[i] ? -t_s : t_s;
    end

    dc_p  = $signed(SY_W'(drive_clamp));
    lim_v = 1'b0;
    if (drive_clamp != '0 && y_acc > dc_p) begin
      y_cl  = dc_p;
      lim_v = 1'b1;
    end else if (drive_clamp != '0 && y_acc < -dc_p) begin
      y_cl  = -dc_p;
      lim_v = 1'b1;
    end else begin
      y_cl = y_acc;
    end
    if (y_cl > Y_MAX) begin
      y_fin = Y_MAX;
      lim_v = 1'b1;
    end else if (y_cl < Y_MIN) begin
      y_fin = Y_MIN;
      lim_v = 1'b1;
    end else begin
      y_fin = y_cl;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: state_next = dead ? ST_OUT : ST_PREP;
      ST_PREP: begin
        mul_start  = 1'b1;
        state_next = ST_MULA;
      end
      ST_MULA: begin
        if (&mul_done) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (&div_done) begin
          state_next = ST_INTEG;
        end
      end
      ST_INTEG: state_next = ST_GAIN;
      ST_GAIN: begin
        mul_start  = 1'b1;
        state_next = ST_MULB;
      end
      ST_MULB: begin
        if (&mul_done) begin
          state_next = ST_TERM;
        end
      end
      ST_TERM:  state_next = ST_ADD1;
      ST_ADD1:  state_next = ST_ADD2;
      ST_ADD2:  state_next = ST_LIMIT;
      ST_LIMIT: state_next = ST_OUT;
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      integ_acc <= '0;
      prev_err  <= '0;
    end else begin
      if (state == ST_CHECK) begin
        prev_err <= e_reg;
      end
      if (state == ST_INTEG) begin
        integ_acc <= i_new[ACC_W-1:0];
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      e_reg    <= err_in;
      e_mag    <= e_mag_in;
      step_eff <= step_in;
    end
    if (state == ST_CHECK) begin
      diff_reg <= (DW+1)'(e_reg) - (DW+1)'(prev_err);
      if (dead) begin
        res_drive <= '0;
        res_dz    <= 1'b1;
        res_lim   <= 1'b0;
      end
    end
    if (state == ST_DIV && (&div_done)) begin
      inc_reg <= inc_v;
      d_mag   <= d_sel[MAG_W-1:0];
    end
    if (state == ST_TERM) begin
      for (int i = 0; i < N_LANE; i++) begin
        term[i] <= term_v[i];
      end
    end
    if (state == ST_ADD1) begin
      y_acc <= SY_W'(term[LANE_P]) + SY_W'(term[LANE_I]);
    end
    if (state == ST_ADD2) begin
      y_acc <= y_acc + SY_W'(term[LANE_D]);
    end
    if (state == ST_LIMIT) begin
      res_drive <= y_fin[DW-1:0];
      res_dz    <= 1'b0;
      res_lim   <= lim_v;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      drive         <= res_drive;
      in_dead_zone  <= res_dz;
      drive_limited <= res_lim;
    end
  end

  `PWD_ASSERT_NOW(a_dead_zone_result, out_valid && in_dead_zone, drive == '0 && !drive_limited, "deadband result not zero")
  `PWD_ASSERT_NOW(a_div_in_phase, div_done[DIV_I] || div_done[DIV_D], state == ST_DIV, "divider finished outside its phase")
  `PWD_ASSERT_NOW(a_integ_clamped, state == ST_GAIN && integ_clamp != '0, integ_mag <= ACC_W'(integ_clamp), "integral beyond clamp")
  `PWD_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second transfer taken while busy")

endmodule

// ===== rtl/pwd_smul.sv =====
// ----------------------------------------------------------------------------
// pwd_smul
// bit-serial unsigned multiplier, one multiplier bit per cycle, lsb first
// ----------------------------------------------------------------------------
module pwd_smul import pwd_pkg::*; #(
  parameter int A_W = ACC_W,
  parameter int B_W = GAIN_W
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               done,
  output logic [A_W+B_W-1:0] prod
);

  localparam int CNT_W = $clog2(B_W);

  logic [A_W-1:0]     mcand;
  logic [A_W+B_W-1:0] acc;
  logic [A_W+B_W-1:0] acc_next;
  logic [A_W:0]       part;
  logic [CNT_W-1:0]   cnt;
  logic               run;

  always_comb begin
    part     = {1'b0, acc[A_W+B_W-1:B_W]} + (acc[0] ? {1'b0, mcand} : '0);
    acc_next = {part, acc[B_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(B_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a;
      acc   <= (A_W+B_W)'(b);
    end else if (run) begin
      acc <= acc_next;
    end
  end

  assign prod = acc;

endmodule

// ===== rtl/pwd_sdiv.sv =====
// ----------------------------------------------------------------------------
// pwd_sdiv
// bit-serial restoring divider, one quotient bit per cycle, msb first
// ----------------------------------------------------------------------------
module pwd_sdiv import pwd_pkg::*; #(
  parameter int N_W = DEF_DATA_WIDTH + STEP_W,
  parameter int D_W = STEP_W
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           done,
  output logic [N_W-1:0] quot
);

  localparam int CNT_W = $clog2(N_W);

  logic [D_W-1:0]   dvs;
  logic [D_W-1:0]   rem;
  logic [D_W-1:0]   rem_next;
  logic [N_W-1:0]   quo;
  logic [D_W:0]     rem_sh;
  logic [D_W:0]     trial;
  logic             fits;
  logic [CNT_W-1:0] cnt;
  logic             run;

  always_comb begin
    rem_sh   = {rem, quo[N_W-1]};
    trial    = rem_sh - {1'b0, dvs};
    fits     = ~trial[D_W];
    rem_next = fits ? trial[D_W-1:0] : rem_sh[D_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(N_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (run) begin
      rem <= rem_next;
      quo <= {quo[N_W-2:0], fits};
    end
  end

  assign quot = quo;

endmodule

// ===== bench/tb_pid_with_deadband.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pid_with_deadband
// self-checking bench for the fixed-point pid controller with deadband
// ----------------------------------------------------------------------------
// An initial block writes gains, deadband and limits while the block is idle,
// then queues error samples: a directed set (field extremes, deadband edges,
// zero time step, clamps and saturation) and random phases with random
// settings. A clocked driver offers the queued samples and computes the
// expected controller output at each accepted transfer; a clocked monitor
// compares every result transfer with the oldest expected one. Both sides
// idle at random, the receiver holds off for long stretches twice, and a
// watchdog ends the run if transfers stop.
// ----------------------------------------------------------------------------
module tb_pid_with_deadband;
  import pwd_pkg::*;

  localparam longint MICROS    = 1_000_000;
  localparam int     FRAC      = DEF_FRAC_BITS;
  localparam longint ACC_MAX   = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint DRIVE_MAX = (longint'(1) <<< (DEF_DATA_WIDTH - 1)) - 1;
  localparam int     HOLD_LEN  = 400;
  localparam int     QUIET_LIM = 4000;
  localparam int     PHASE_LEN = 125;

  // no register at this index
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd6;

  typedef struct packed {
    logic [DEF_DATA_WIDTH-1:0] err;
    logic [STEP_W-1:0]         step;
  } pid_sample_t;

  typedef struct packed {
    logic [DEF_DATA_WIDTH-1:0] drive;
    logic                      dead;
    logic                      limited;
  } pid_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_addr = '0;
  logic [CFG_W-1:0]          cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [DEF_DATA_WIDTH-1:0] err_in = '0;
  logic [STEP_W-1:0]         step_us = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [DEF_DATA_WIDTH-1:0] drive;
  logic                      in_dead_zone;
  logic                      drive_limited;

  pid_sample_t sample_q[$];
  pid_result_t drive_expect_q[$];

  // controller copy: settings and state
  longint p_gain = 0, i_gain = 0, d_gain = 0;
  longint band = 0, i_limit = 0, out_limit = 0;
  longint integ = 0, last_err = 0;

  int idle_pct = 21;
  int mismatches = 0;
  int results_seen = 0;
  int hold_left = 0;
  int quiet = 0;

  pid_with_deadband u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .err_in       (err_in),
    .step_us      (step_us),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .drive        (drive),
    .in_dead_zone (in_dead_zone),
    .drive_limited(drive_limited)
  );

  always #5 clk = ~clk;

  function automatic longint sat48(input longint v);
    if (v > ACC_MAX) return ACC_MAX;
    if (v < -ACC_MAX - 1) return -ACC_MAX - 1;
    return v;
  endfunction

  // gain times value, magnitude truncated, capped at the term limit
  function automatic longint gain_term(input longint g, input longint v);
    logic [63:0]  mg;
    logic [63:0]  mv;
    logic [127:0] prod;
    longint       r;
    mg = (g < 0) ? 64'(-g) : 64'(g);
    mv = (v < 0) ? 64'(-v) : 64'(v);
    prod = ({64'd0, mg} * {64'd0, mv}) >> FRAC;
    r = (prod > {64'd0, TERM_LIM}) ? longint'(TERM_LIM) : longint'(prod[63:0]);
    return ((g < 0) != (v < 0)) ? -r : r;
  endfunction

  function automatic longint add_sat(input longint a, input longint b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63])
      return s[64] ? longint'(64'h8000_0000_0000_0000) : longint'(64'h7FFF_FFFF_FFFF_FFFF);
    return longint'(s[63:0]);
  endfunction

  function automatic pid_result_t pid_predict(input logic [DEF_DATA_WIDTH-1:0] err_raw,
                                              input logic [STEP_W-1:0] step_raw);
    longint      e;
    longint      st;
    longint      d;
    longint      y;
    logic        lim;
    pid_result_t r;
    e = longint'(signed'(err_raw));
    st = (step_raw == '0) ? longint'(DEF_MIN_STEP_US) : longint'({44'd0, step_raw});
    if (e < band && e > -band) begin
      last_err = e;
      r.drive = '0;
      r.dead = 1'b1;
      r.limited = 1'b0;
      return r;
    end
    integ = integ + (e * st) / MICROS;
    if (i_limit > 0) begin
      if (integ > i_limit) integ = i_limit;
      if (integ < -i_limit) integ = -i_limit;
    end else begin
      integ = sat48(integ);
    end
    d = sat48(((e - last_err) * MICROS) / st);
    last_err = e;
    y = gain_term(p_gain, e);
    y = add_sat(y, gain_term(i_gain, integ));
    y = add_sat(y, gain_term(d_gain, d));
    lim = 1'b0;
    if (out_limit > 0) begin
      if (y > out_limit) begin
        y = out_limit;
        lim = 1'b1;
      end
      if (y < -out_limit) begin
        y = -out_limit;
        lim = 1'b1;
      end
    end
    if (y > DRIVE_MAX) begin
      y = DRIVE_MAX;
      lim = 1'b1;
    end
    if (y < -DRIVE_MAX - 1) begin
      y = -DRIVE_MAX - 1;
      lim = 1'b1;
    end
    r.drive = y[DEF_DATA_WIDTH-1:0];
    r.dead = 1'b0;
    r.limited = lim;
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_PROP_GAIN:   p_gain = longint'(signed'(val));
      REG_INTEG_GAIN:  i_gain = longint'(signed'(val));
      REG_DERIV_GAIN:  d_gain = longint'(signed'(val));
      REG_DEAD_ZONE:   band = longint'({33'd0, val[CLAMP_W-1:0]});
      REG_INTEG_CLAMP: i_limit = longint'({33'd0, val[CLAMP_W-1:0]});
      REG_DRIVE_CLAMP: out_limit = longint'({33'd0, val[CLAMP_W-1:0]});
      default: ;
    endcase
  endtask

  task automatic configure(input logic [CFG_W-1:0] kp, input logic [CFG_W-1:0] ki,
                           input logic [CFG_W-1:0] kd, input logic [CFG_W-1:0] dz,
                           input logic [CFG_W-1:0] ic, input logic [CFG_W-1:0] dc);
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEG_GAIN, ki);
    write_reg(REG_DERIV_GAIN, kd);
    write_reg(REG_DEAD_ZONE, dz);
    write_reg(REG_INTEG_CLAMP, ic);
    write_reg(REG_DRIVE_CLAMP, dc);
    write_reg(REG_UNUSED, $urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_sample(input logic [DEF_DATA_WIDTH-1:0] e, input logic [STEP_W-1:0] s);
    pid_sample_t smp;
    smp.err = e;
    smp.step = s;
    sample_q.push_back(smp);
  endtask

  // wait until every queued sample is through and every result is back
  task automatic drain();
    while (sample_q.size() != 0 || in_valid || drive_expect_q.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] rand_gain();
    case ($urandom_range(7))
      0: return '0;
      1, 2, 3: return $urandom_range(2**18 - 1) - 2**17;
      4: return 32'h7FFF_FFFF;
      5: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_mag();
    case ($urandom_range(6))
      0, 1: return '0;
      2, 3: return $urandom_range(2**18);
      4: return 32'h7FFF_FFFF;
      default: return {1'b0, 31'($urandom)};
    endcase
  endfunction

  function automatic logic [DEF_DATA_WIDTH-1:0] rand_err();
    logic [DEF_DATA_WIDTH-1:0] v;
    case ($urandom_range(9))
      0, 1, 2: begin
        // around the deadband edge, either sign
        v = band[DEF_DATA_WIDTH-1:0] + $urandom_range(8) - 4;
        if ($urandom_range(1) == 1) v = -v;
      end
      3, 4: v = $urandom_range(2**19) - 2**18;
      5, 6, 7: v = $urandom;
      default: begin
        case ($urandom_range(4))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = '0;
          3: v = '1;
          default: v = 32'd1;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic logic [STEP_W-1:0] rand_step();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3, 4, 5: return STEP_W'($urandom_range(2000, 1));
      default: return STEP_W'($urandom);
    endcase
  endfunction

  // driver: offers queued samples, predicts at each input transfer
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      err_in <= '0;
      step_us <= '0;
    end else begin
      if (in_valid && in_ready)
        drive_expect_q.push_back(pid_predict(err_in, step_us));
      if (!in_valid || in_ready) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          pid_sample_t smp;
          smp = sample_q.pop_front();
          in_valid <= 1'b1;
          err_in <= smp.err;
          step_us <= smp.step;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks result transfers, drives out_ready
  always @(posedge clk) begin : monitor
    pid_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (results_seen == 60 || results_seen == 600) hold_left = HOLD_LEN;
        if (drive_expect_q.size() == 0) begin
          $error("result transfer with nothing expected: drive %h", drive);
          mismatches++;
        end else begin
          want = drive_expect_q.pop_front();
          if (drive !== want.drive) begin
            $error("drive: expected %h actual %h", want.drive, drive);
            mismatches++;
          end
          if (in_dead_zone !== want.dead) begin
            $error("in_dead_zone: expected %b actual %b", want.dead, in_dead_zone);
            mismatches++;
          end
          if (drive_limited !== want.limited) begin
            $error("drive_limited: expected %b actual %b", want.limited, drive_limited);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet <= 0;
      end else if (quiet == QUIET_LIM) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin : stimulus
    int ph;
    int n;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // plain gains, no deadband, no limits
    configure(32'h0001_0000, 32'h0002_0000, 32'h0000_0100, '0, '0, '0);
    add_sample(32'h0000_0000, 20'd0);
    add_sample(32'h0000_0001, 20'd1);
    add_sample(32'hFFFF_FFFF, 20'd100);
    add_sample(32'h7FFF_FFFF, 20'hFFFFF);
    add_sample(32'h8000_0000, 20'd1);
    add_sample(32'h8000_0000, 20'hFFFFF);
    add_sample(32'h7FFF_FFFF, 20'd1);
    add_sample(32'h0001_0000, 20'd0);
    add_sample(32'hFFFF_0000, 20'd1000);
    drain();

    // deadband edges, integral clamp and output clamp
    configure(32'hFFFF_0000, 32'h0001_0000, '0, 32'h0000_8000, 32'h0000_4000, 32'h0000_C000);
    add_sample(32'h0000_8000, 20'd1000);
    add_sample(32'h0000_8000, 20'd500000);
    add_sample(32'h0000_7FFF, 20'd10);
    add_sample(32'hFFFF_8000, 20'd10);
    add_sample(32'hFFFF_8001, 20'd10);
    add_sample(32'h0000_0000, 20'd0);
    add_sample(32'h0010_0000, 20'hFFFFF);
    add_sample(32'hFFF0_0000, 20'hFFFFF);
    drain();

    // largest settings: only the outermost errors leave the deadband
    configure(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF);
    add_sample(32'h7FFF_FFFF, 20'd1);
    add_sample(32'h8000_0000, 20'd1);
    add_sample(32'h8000_0001, 20'd1);
    add_sample(32'h7FFF_FFFE, 20'd5);
    add_sample(32'h0000_0000, 20'd0);
    drain();

    // everything zero
    configure('0, '0, '0, '0, '0, '0);
    add_sample(32'h1234_5678, 20'h54321);
    add_sample(32'h8000_0000, 20'd0);
    add_sample(32'h7FFF_FFFF, 20'hFFFFF);
    drain();

    for (ph = 0; ph < 8; ph++) begin
      idle_pct = (ph == 2) ? 0 : 21;
      configure(rand_gain(), rand_gain(), rand_gain(), rand_mag(), rand_mag(), rand_mag());
      for (n = 0; n < PHASE_LEN; n++)
        add_sample(rand_err(), rand_step());
      drain();
    end

    repeat (140) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
